// ===== rtl/ksel_pkg.sv =====
`default_nettype none
package ksel_pkg;

    // Fixed field widths of the ports
    localparam int unsigned RANK_WIDTH   = 5;
    localparam int unsigned SAMPLE_WIDTH = 32;

    // Per-cell control, driven by the top level into each cell
    typedef struct packed {
        logic load;   // take the next value at this edge
        logic valid;  // cell holds a kept value
    } ksel_cell_ctl_t;

endpackage
`default_nettype wire

// ===== rtl/ksel_cell.sv =====
`default_nettype none
module ksel_cell #(
    parameter int unsigned DATA_WIDTH = 32
) (
    input  wire                       clk,
    input  ksel_pkg::ksel_cell_ctl_t  ctl,
    input  wire  [DATA_WIDTH-1:0]     ins_value,
    input  wire                       left_gt,
    input  wire  [DATA_WIDTH-1:0]     left_value,
    output logic                      gt,
    output logic [DATA_WIDTH-1:0]     value,
    output logic [DATA_WIDTH-1:0]     value_next
);
    import ksel_pkg::*;

    logic [DATA_WIDTH-1:0] value_reg;

    // An empty cell always counts as larger than the new word
    assign gt = !ctl.valid || ($signed(value_reg) > $signed(ins_value));

    // Keep, shift in from the left neighbor, or take the new word
    always_comb
    begin
        if (!gt)
        begin
            value_next = value_reg;
        end
        else if (left_gt)
        begin
            value_next = left_value;
        end
        else
        begin
            value_next = ins_value;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            value_reg <= value_next;
        end
    end

    assign value = value_reg;

endmodule
`default_nettype wire

// ===== rtl/streaming_kth_smallest_selector.sv =====
`default_nettype none
// Channel | Direction | Handshake             | Payload
// input   | in        | in_valid / in_ready   | sample_value, end_of_set
// result  | out       | out_valid / out_ready | kth_value, found
// config  | in        | cfg_wr_en             | cfg_wr_data (k_rank)
//
// One input word is taken every cycle unless input is stalled; the sorted
// insertion through the cell chain finishes in the cycle the word is accepted.
// A result appears in the cycle after the accepted end-of-set word and sits in
// the output register; input stalls only while that register is full and
// out_ready is low.
// Reset clears the fill count, the output valid and sets k_rank to 1; the
// cell contents are not cleared and are masked by the fill count.
module streaming_kth_smallest_selector #(
    parameter int unsigned MAX_K      = 16,
    parameter int unsigned DATA_WIDTH = 32
) (
    input  wire                                   clk,
    input  wire                                   rst_n,
    input  wire                                   in_valid,
    output logic                                  in_ready,
    input  wire  [ksel_pkg::SAMPLE_WIDTH-1:0]     sample_value,
    input  wire                                   end_of_set,
    output logic                                  out_valid,
    input  wire                                   out_ready,
    output logic [ksel_pkg::SAMPLE_WIDTH-1:0]     kth_value,
    output logic                                  found,
    input  wire                                   cfg_wr_en,
    input  wire  [ksel_pkg::RANK_WIDTH-1:0]       cfg_wr_data
);
    import ksel_pkg::*;

    localparam int unsigned CW = $clog2(MAX_K + 1);            // fill count
    localparam int unsigned IW = (MAX_K > 1) ? $clog2(MAX_K) : 1; // cell index
    localparam int unsigned KW = (CW > RANK_WIDTH) ? CW : RANK_WIDTH;

    logic [RANK_WIDTH-1:0] k_rank_reg;
    logic [CW-1:0]         count_reg, count_next, count_ins;
    logic                  out_valid_reg, out_valid_next;
    logic [SAMPLE_WIDTH-1:0] kth_reg, kth_next;
    logic                  found_reg, found_next;

    logic                  accept;
    logic [DATA_WIDTH-1:0] ins_value;
    logic [KW-1:0]         k_sel;
    logic [IW-1:0]         k_idx;
    logic [DATA_WIDTH-1:0] pick;

    logic [DATA_WIDTH-1:0] cell_value [MAX_K];
    logic [DATA_WIDTH-1:0] cell_next  [MAX_K];
    logic                  cell_gt    [MAX_K];

    // Hold input only while a finished result waits to be taken
    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    // Fit the port word to the stored width: zero-extend or truncate
    always_comb
    begin
        for (int b = 0; b < DATA_WIDTH; b++)
        begin
            ins_value[b] = (b < SAMPLE_WIDTH) ? sample_value[b] : 1'b0;
        end
    end

    // The chain: cell 0 holds the smallest word; the last cell drops on overflow
    for (genvar i = 0; i < MAX_K; i++)
    begin : g_cell
        ksel_cell_ctl_t ctl;
        logic                  lgt;
        logic [DATA_WIDTH-1:0] lval;

        assign ctl.load  = accept;
        assign ctl.valid = (count_reg > CW'(i));

        if (i == 0)
        begin : g_head
            assign lgt  = 1'b0;
            assign lval = ins_value;
        end
        else
        begin : g_link
            assign lgt  = cell_gt[i-1];
            assign lval = cell_value[i-1];
        end

        ksel_cell #(
            .DATA_WIDTH (DATA_WIDTH)
        ) u_cell (
            .clk        (clk),
            .ctl        (ctl),
            .ins_value  (ins_value),
            .left_gt    (lgt),
            .left_value (lval),
            .gt         (cell_gt[i]),
            .value      (cell_value[i]),
            .value_next (cell_next[i])
        );
    end

    // Clamp rank into 1..MAX_K
    always_comb
    begin
        if (k_rank_reg == '0)
        begin
            k_sel = KW'(1);
        end
        else if (KW'(k_rank_reg) > KW'(MAX_K))
        begin
            k_sel = KW'(MAX_K);
        end
        else
        begin
            k_sel = KW'(k_rank_reg);
        end
    end

    assign k_idx = IW'(k_sel - KW'(1));
    assign pick  = cell_next[k_idx];

    // Count after taking the current word; saturates once the chain is full
    assign count_ins = (count_reg == CW'(MAX_K)) ? count_reg : count_reg + CW'(1);

    always_comb
    begin
        count_next     = count_reg;
        out_valid_next = out_valid_reg;
        kth_next       = kth_reg;
        found_next     = found_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (accept)
        begin
            count_next = end_of_set ? '0 : count_ins;
            if (end_of_set)
            begin
                out_valid_next = 1'b1;
                found_next     = (KW'(count_ins) >= k_sel);
                for (int b = 0; b < SAMPLE_WIDTH; b++)
                begin
                    kth_next[b] = (b < DATA_WIDTH) ? pick[b] : 1'b0;
                end
                if (KW'(count_ins) < k_sel)
                begin
                    kth_next = '0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_rank_reg    <= RANK_WIDTH'(1);
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                k_rank_reg <= cfg_wr_data;
            end
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload needs no reset
    always_ff @(posedge clk)
    begin
        kth_reg   <= kth_next;
        found_reg <= found_next;
    end

    assign out_valid = out_valid_reg;
    assign kth_value = kth_reg;
    assign found     = found_reg;

endmodule
`default_nettype wire

// ===== rtl/ksel_checker.sv =====
`default_nettype none
module ksel_checker (
    input wire        clk,
    input wire        rst_n,
    input wire        in_valid,
    input wire        in_ready,
    input wire        end_of_set,
    input wire        out_valid,
    input wire        out_ready,
    input wire [31:0] kth_value,
    input wire        found
);

    // Stalled result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(kth_value) && $stable(found))
        else $error("result word changed while stalled");

    // Not-found result carries zero
    a_nf_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !found |-> kth_value == 32'd0)
        else $error("not-found result with nonzero value");

    // A new result follows only an accepted end-of-set word
    a_cause: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !$past(out_valid && !out_ready)
        |-> $past(in_valid && in_ready && end_of_set))
        else $error("result without end-of-set word");

    // Input is taken whenever the output register is empty
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty output");

endmodule

bind streaming_kth_smallest_selector ksel_checker u_ksel_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .end_of_set (end_of_set),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .kth_value  (kth_value),
    .found      (found)
);
`default_nettype wire

// ===== dv/ksel_result_checker.sv =====
module ksel_result_checker #(
    parameter int unsigned MAX_K = 16
) (
    input  wire                               clk,
    input  wire                               rst_n,
    input  wire                               in_valid,
    input  wire                               in_ready,
    input  wire  [ksel_pkg::SAMPLE_WIDTH-1:0] sample_value,
    input  wire                               end_of_set,
    input  wire                               out_valid,
    input  wire                               out_ready,
    input  wire  [ksel_pkg::SAMPLE_WIDTH-1:0] kth_value,
    input  wire                               found,
    input  wire                               cfg_wr_en,
    input  wire  [ksel_pkg::RANK_WIDTH-1:0]   cfg_wr_data,
    output int unsigned                       mismatch_count,
    output int unsigned                       pending_results,
    output int unsigned                       results_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    import ksel_pkg::*;

    typedef struct packed {
        logic [SAMPLE_WIDTH-1:0] kth;
        logic                    found;
    } kth_result_t;

    // Smallest values of the open set, ascending; only the first kept_n are live
    logic signed [SAMPLE_WIDTH-1:0] kept_sorted [MAX_K];
    int unsigned                    kept_n;
    logic [RANK_WIDTH-1:0]          rank_reg;
    kth_result_t                    expected_kth [$];

    // Insert one word into the sorted store; drop the largest once full
    function automatic void keep_smallest(input logic signed [SAMPLE_WIDTH-1:0] v);
        int unsigned pos;
        if (kept_n >= MAX_K)
        begin
            if (v >= kept_sorted[MAX_K-1])
                return;
            pos = MAX_K - 1;
        end
        else
        begin
            pos = kept_n;
            kept_n++;
        end
        while (pos > 0 && kept_sorted[pos-1] > v)
        begin
            kept_sorted[pos] = kept_sorted[pos-1];
            pos--;
        end
        kept_sorted[pos] = v;
    endfunction

    // Close the set: read the rank now, clamp it, and empty the store
    function automatic kth_result_t close_set();
        kth_result_t res;
        int unsigned k;
        k = (rank_reg == 0) ? 1 : ((rank_reg > MAX_K) ? MAX_K : rank_reg);
        if (kept_n >= k)
        begin
            res.kth   = kept_sorted[k-1];
            res.found = 1'b1;
        end
        else
        begin
            res.kth   = '0;
            res.found = 1'b0;
        end
        kept_n = 0;
        return res;
    endfunction

    function automatic void flag_failure(input string msg);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("[%0t] ERROR: %s", $realtime, msg);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        kth_result_t want;
        if (!rst_n)
        begin
            kept_n = 0;
            rank_reg = RANK_WIDTH'(1);
            expected_kth.delete();
            mismatch_count = 0;
            results_checked = 0;
        end
        else
        begin
            if (cfg_wr_en)
                rank_reg = cfg_wr_data;

            // Check the result before queueing a new one: a word taken at
            // this edge cannot have its result out at the same edge.
            if (out_valid && out_ready)
            begin
                if (expected_kth.size() == 0)
                    flag_failure($sformatf("result with none expected: kth_value=%0d found=%0b",
                                           $signed(kth_value), found));
                else
                begin
                    want = expected_kth.pop_front();
                    results_checked++;
                    if (kth_value !== want.kth || found !== want.found)
                        flag_failure($sformatf(
                            "result %0d: kth_value exp %0d got %0d, found exp %0b got %0b",
                            results_checked, $signed(want.kth), $signed(kth_value),
                            want.found, found));
                end
            end

            if (in_valid && in_ready)
            begin
                keep_smallest(sample_value);
                if (end_of_set)
                begin
                    want = close_set();
                    expected_kth.insert(expected_kth.size(), want);
                end
            end
        end
        pending_results = expected_kth.size();
    end

endmodule

// ===== dv/streaming_kth_smallest_selector_tb.sv =====
module streaming_kth_smallest_selector_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ksel_pkg::*;

    localparam int unsigned MAX_K          = 16;
    localparam int unsigned WORDS_PER_LEG  = 100;
    localparam int unsigned WATCHDOG_LIMIT = 2000;

    logic                    clk;
    logic                    rst_n        = 1'b0;
    logic                    in_valid     = 1'b0;
    logic                    in_ready;
    logic [SAMPLE_WIDTH-1:0] sample_value = '0;
    logic                    end_of_set   = 1'b0;
    logic                    out_valid;
    logic                    out_ready    = 1'b0;
    logic [SAMPLE_WIDTH-1:0] kth_value;
    logic                    found;
    logic                    cfg_wr_en    = 1'b0;
    logic [RANK_WIDTH-1:0]   cfg_wr_data  = '0;

    int unsigned mismatch_count;
    int unsigned pending_results;
    int unsigned results_checked;

    // Pacing knobs, in percent, retuned per leg of the run
    int unsigned sender_idle_pct = 0;
    int unsigned recv_stall_pct  = 0;

    int unsigned words_sent  = 0;
    int unsigned sets_sent   = 0;
    int unsigned rank_writes = 0;
    int unsigned idle_cycles = 0;

    streaming_kth_smallest_selector #(
        .MAX_K      (MAX_K),
        .DATA_WIDTH (SAMPLE_WIDTH)
    ) DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .sample_value (sample_value),
        .end_of_set   (end_of_set),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .kth_value    (kth_value),
        .found        (found),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data)
    );

    ksel_result_checker #(
        .MAX_K (MAX_K)
    ) checker_inst (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .sample_value    (sample_value),
        .end_of_set      (end_of_set),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .kth_value       (kth_value),
        .found           (found),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .mismatch_count  (mismatch_count),
        .pending_results (pending_results),
        .results_checked (results_checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Redraw out_ready at every edge; a zero stall percent keeps it high
    always @(posedge clk)
        out_ready <= ($urandom_range(99) >= recv_stall_pct);

    // Abort when no word moves in either direction for too long
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || cfg_wr_en)
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Watchdog: %0d cycles without a word moving", idle_cycles);
            $display("Test completed with failures");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // Offer one word and hold it until taken. An idle gap drops valid first;
    // back-to-back words keep valid high with a single assignment per edge.
    task automatic send_word(input logic [SAMPLE_WIDTH-1:0] v, input logic eos);
        if ($urandom_range(99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < sender_idle_pct);
        end
        in_valid     <= 1'b1;
        sample_value <= v;
        end_of_set   <= eos;
        do @(posedge clk); while (!in_ready);
        words_sent++;
        if (eos)
            sets_sent++;
    endtask

    // Stop sending and wait until every queued result has been taken.
    task automatic drain_results();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending_results != 0);
        repeat (2) @(posedge clk);
    endtask

    task automatic write_rank(input logic [RANK_WIDTH-1:0] r);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= r;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        rank_writes++;
    endtask

    // Mostly legal ranks, sometimes zero or above MAX_K to hit the clamps
    function automatic logic [RANK_WIDTH-1:0] pick_rank();
        if ($urandom_range(3) == 0)
            return RANK_WIDTH'($urandom_range((1 << RANK_WIDTH) - 1));
        return RANK_WIDTH'($urandom_range(MAX_K, 1));
    endfunction

    // Small values force duplicates, extremes test the signed order
    function automatic logic [SAMPLE_WIDTH-1:0] random_sample();
        case ($urandom_range(9))
            0, 1, 2: return $urandom_range(16) - 8;
            3:
            begin
                case ($urandom_range(5))
                    0:       return 32'h7FFF_FFFF;
                    1:       return 32'h8000_0000;
                    2:       return 32'h0000_0000;
                    3:       return 32'hFFFF_FFFF;
                    4:       return 32'h8000_0001;
                    default: return 32'h7FFF_FFFE;
                endcase
            end
            default: return $urandom;
        endcase
    endfunction

    // One set with random length and shape: most fit in the store, some
    // overflow it so the largest kept word gets dropped.
    task automatic send_random_set();
        int unsigned             len;
        int unsigned             shape;
        int unsigned             i;
        logic [SAMPLE_WIDTH-1:0] base;
        logic [SAMPLE_WIDTH-1:0] v;
        case ($urandom_range(9))
            0, 1, 2, 3, 4, 5: len = $urandom_range(MAX_K + 2, 1);
            6, 7, 8:          len = $urandom_range(40, MAX_K + 1);
            default:          len = 1;
        endcase
        shape = $urandom_range(3);
        base  = random_sample();
        for (i = 0; i < len; i++)
        begin
            case (shape)
                1:       v = base + i;
                2:       v = base - i;
                default: v = random_sample();
            endcase
            send_word(v, i == len - 1);
        end
    endtask

    initial
    begin : stimulus
        int unsigned leg;
        int unsigned leg_start;
        int unsigned i;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: default rank 1 picks the most negative of the extremes
        send_word(32'h7FFF_FFFF, 1'b0);
        send_word(32'h8000_0000, 1'b0);
        send_word(32'h0000_0000, 1'b0);
        send_word(32'hFFFF_FFFF, 1'b1);

        // Rank zero behaves as rank one; duplicates sit in separate entries
        drain_results();
        write_rank('0);
        send_word(32'd5, 1'b0);
        send_word(32'd5, 1'b0);
        send_word(32'd3, 1'b1);

        // Retune rank in the middle of a set; only the value at the end counts
        send_word(32'hFFFF_FFF9, 1'b0);
        drain_results();
        write_rank(RANK_WIDTH'(2));
        send_word(32'hFFFF_FFF9, 1'b1);

        // Too few words for the rank: expect not found
        drain_results();
        write_rank(RANK_WIDTH'(MAX_K));
        send_word(32'd42, 1'b1);

        // Rank beyond MAX_K clamps; a descending run overflows the store
        drain_results();
        write_rank('1);
        for (i = 0; i <= MAX_K; i++)
            send_word(SAMPLE_WIDTH'(100 - i), i == MAX_K);

        // Random legs: clean, sender idle, receiver stalling, both
        for (leg = 0; leg < 4; leg++)
        begin
            case (leg)
                0:       begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin sender_idle_pct = 80; recv_stall_pct = 0;  end
                2:       begin sender_idle_pct = 0;  recv_stall_pct = 80; end
                default: begin sender_idle_pct = 32; recv_stall_pct = 32; end
            endcase
            drain_results();
            write_rank(pick_rank());
            leg_start = words_sent;
            while (words_sent - leg_start < WORDS_PER_LEG)
            begin
                if ($urandom_range(3) == 0)
                begin
                    // Hold the sender until the block is empty, then retune k
                    drain_results();
                    write_rank(pick_rank());
                end
                send_random_set();
            end
        end

        drain_results();
        repeat (4) @(posedge clk);

        $display("Sent %0d words in %0d sets under four pacing legs, %0d rank writes",
                 words_sent, sets_sent, rank_writes);
        $display("Checked %0d k-th smallest results, %0d mismatches",
                 results_checked, mismatch_count);
        if (mismatch_count == 0 && pending_results == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/ksel_pkg.sv
rtl/ksel_cell.sv
rtl/streaming_kth_smallest_selector.sv
rtl/ksel_checker.sv
dv/ksel_result_checker.sv
dv/streaming_kth_smallest_selector_tb.sv
